### rtl/rpt_pkg.sv
`timescale 1ns / 1ps

package rpt_pkg;

   // Field widths.
   localparam int TICK_W    = 24;
   localparam int SEEK_W    = 26;
   localparam int DIVISOR_W = 8;
   localparam int MINCNT_W  = 10;
   localparam int COUNT_W   = 9;
   localparam int INDEX_W   = 9;
   localparam int VALUE_W   = 16;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 3;

   localparam int BUFFER_DEPTH_DEFAULT = 512;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
   localparam int DIV_STEPS = TICK_W;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Register file.
   localparam int CSR_AW     = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_PREAMBLE_MIN = 3'd0;
   localparam logic [2:0] REG_PULSE_MIN    = 3'd1;
   localparam logic [2:0] REG_END_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_SEEK_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_DIVISOR      = 3'd4;
   localparam logic [2:0] REG_MIN_COUNT    = 3'd5;

   localparam logic [TICK_W-1:0]    RST_PREAMBLE_MIN = 24'd3000;
   localparam logic [TICK_W-1:0]    RST_PULSE_MIN    = 24'd50;
   localparam logic [TICK_W-1:0]    RST_END_TIMEOUT  = 24'd5000;
   localparam logic [SEEK_W-1:0]    RST_SEEK_TIMEOUT = 26'd20000;
   localparam logic [DIVISOR_W-1:0] RST_DIVISOR      = 8'd32;
   localparam logic [MINCNT_W-1:0]  RST_MIN_COUNT    = 10'd50;

   typedef enum logic [STATUS_W-1:0] {
      PH_IDLE         = 3'd0,
      PH_SEEK         = 3'd1,
      PH_CAPTURE      = 3'd2,
      PH_DONE         = 3'd3,
      PH_SEEK_TIMEOUT = 3'd4,
      PH_SHORT        = 3'd5,
      PH_TOO_FEW      = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ZERO
   } ctrl_state_type;

   // Follow-up work that a request leaves for the controller.
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_DIV,
      ACT_ZERO2
   } act_type;

   typedef struct packed {
      logic [TICK_W-1:0]    preamble_min;
      logic [TICK_W-1:0]    pulse_min;
      logic [TICK_W-1:0]    end_timeout;
      logic [SEEK_W-1:0]    seek_timeout;
      logic [DIVISOR_W-1:0] divisor;
      logic [MINCNT_W-1:0]  min_count;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic div_start;
      logic store_div;
      logic store_zero2;
   } ctrl_cmd_type;

   typedef struct packed {
      act_type action;
      logic    div_done;
   } dp_status_type;

endpackage

### rtl/rpt_ram.sv
`timescale 1ns / 1ps

module rpt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rpt_div.sv
`timescale 1ns / 1ps

module rpt_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rpt_pkg::TICK_W-1:0]       dividend,
   input  logic [rpt_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             done,
   output logic [rpt_pkg::VALUE_W-1:0]      quotient
);

   import rpt_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic [TICK_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;

   // Restoring division, one quotient bit per cycle, most significant first.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[TICK_W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = (divisor == '0) ? DIVISOR_W'(1) : divisor;
         cnt_in = CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[TICK_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[TICK_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = (|quo_ff[TICK_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : quo_ff[VALUE_W-1:0];

endmodule

### rtl/rpt_ctrl.sv
`timescale 1ns / 1ps

module rpt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  rpt_pkg::dp_status_type dp_status,
   output rpt_pkg::ctrl_cmd_type  cmd
);

   import rpt_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           ready;
   logic           accept;

   // The result register is free when empty or being emptied this cycle.
   assign ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept = ready && req_tvalid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (dp_status.action)
                  ACT_DIV:   state_in = ST_DIV;
                  ACT_ZERO2: state_in = ST_ZERO;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (dp_status.div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_ZERO: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.step      = accept;
            cmd.div_start = accept && (dp_status.action == ACT_DIV);
         end
         ST_DIV:  cmd.store_div   = dp_status.div_done;
         ST_ZERO: cmd.store_zero2 = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = ready;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/rpt_datapath.sv
`timescale 1ns / 1ps

module rpt_datapath #(
   parameter int BUFFER_DEPTH = rpt_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rpt_pkg::cfg_type              cfg,
   input  rpt_pkg::ctrl_cmd_type         cmd,
   output rpt_pkg::dp_status_type        dp_status,
   input  logic [rpt_pkg::CMD_W-1:0]     req_command,
   input  logic                          req_level,
   input  logic [rpt_pkg::INDEX_W-1:0]   req_index,
   output logic [rpt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rpt_pkg::COUNT_W-1:0]   rsp_count,
   output logic [rpt_pkg::VALUE_W-1:0]   rsp_data
);

   import rpt_pkg::*;

   localparam int AW     = $clog2(BUFFER_DEPTH);
   localparam int WIDX_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CW     = (WIDX_W > MINCNT_W) ? WIDX_W : MINCNT_W;

   phase_type          phase_ff, phase_in;
   logic               toggle_ff, toggle_in;
   logic [TICK_W-1:0]  pulse_ff, pulse_in;
   logic [SEEK_W-1:0]  seek_ff, seek_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic [COUNT_W-1:0] rcount_ff, rcount_in;
   logic [AW-1:0]      pend_ff, pend_in;

   logic [STATUS_W-1:0] status_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                rd_sel_ff;

   act_type           action;
   logic              zero_we;
   logic              finish;
   logic              rd_en;
   logic              in_range;
   logic [TICK_W-1:0] p_inc;
   logic [TICK_W-1:0] p_seek;
   logic [TICK_W-1:0] dividend;
   logic [WIDX_W-1:0] widx_inc;

   logic                div_done;
   logic [VALUE_W-1:0]  quotient;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [VALUE_W-1:0]  ram_wdata;
   logic [VALUE_W-1:0]  ram_rdata;

   assign p_inc    = (pulse_ff != TICK_MAX) ? pulse_ff + TICK_W'(1) : pulse_ff;
   assign p_seek   = (!toggle_ff && !req_level) ? p_inc : pulse_ff;
   assign widx_inc = widx_ff + WIDX_W'(1);
   assign in_range = (32'(req_index) < 32'(BUFFER_DEPTH));

   // Next architectural state for the request at the input.
   always_comb begin
      phase_in  = phase_ff;
      toggle_in = toggle_ff;
      pulse_in  = pulse_ff;
      seek_in   = seek_ff;
      widx_in   = widx_ff;
      rcount_in = rcount_ff;
      pend_in   = pend_ff;
      action    = ACT_NONE;
      zero_we   = 1'b0;
      finish    = 1'b0;
      rd_en     = 1'b0;
      dividend  = pulse_ff;
      case (req_command)
         CMD_TICK: begin
            case (phase_ff)
               PH_SEEK: begin
                  seek_in  = seek_ff + SEEK_W'(1);
                  pulse_in = p_seek;
                  if (seek_in >= cfg.seek_timeout) begin
                     phase_in = PH_SEEK_TIMEOUT;
                  end else if (toggle_ff) begin
                     if (!req_level) begin
                        toggle_in = 1'b0;
                        pulse_in  = TICK_W'(1);
                     end
                  end else if (req_level) begin
                     toggle_in = 1'b1;
                     if (p_seek >= cfg.preamble_min) begin
                        // Preamble found: its length becomes the first entry.
                        widx_in  = WIDX_W'(1);
                        phase_in = PH_CAPTURE;
                        pulse_in = TICK_W'(1);
                        action   = ACT_DIV;
                        dividend = p_seek;
                        pend_in  = '0;
                     end else begin
                        pulse_in = '0;
                     end
                  end
               end
               PH_CAPTURE: begin
                  if (req_level == toggle_ff) begin
                     pulse_in = p_inc;
                     if (p_inc > cfg.end_timeout) begin
                        if (p_inc < cfg.pulse_min) begin
                           phase_in = PH_SHORT;
                        end else begin
                           zero_we = 1'b1;
                           widx_in = widx_inc;
                           finish  = 1'b1;
                        end
                     end
                  end else if (pulse_ff < cfg.pulse_min) begin
                     phase_in = PH_SHORT;
                  end else if (pulse_ff > cfg.end_timeout) begin
                     zero_we = 1'b1;
                     widx_in = widx_inc;
                     finish  = 1'b1;
                  end else begin
                     action    = ACT_DIV;
                     dividend  = pulse_ff;
                     pend_in   = widx_ff[AW-1:0];
                     widx_in   = widx_inc;
                     toggle_in = ~toggle_ff;
                     pulse_in  = TICK_W'(1);
                     finish    = (32'(widx_inc) >= 32'(BUFFER_DEPTH));
                  end
                  if (finish) begin
                     if (CW'(widx_inc) >= CW'(cfg.min_count)) begin
                        phase_in  = PH_DONE;
                        rcount_in = COUNT_W'(CW'(widx_ff));
                        // A timed-out ending also clears the slot after it.
                        if (zero_we && (32'(widx_inc) < 32'(BUFFER_DEPTH))) begin
                           action  = ACT_ZERO2;
                           pend_in = widx_inc[AW-1:0];
                        end
                     end else begin
                        phase_in  = PH_TOO_FEW;
                        rcount_in = '0;
                     end
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
         CMD_START: begin
            phase_in  = PH_SEEK;
            toggle_in = 1'b1;
            pulse_in  = '0;
            seek_in   = '0;
            widx_in   = '0;
            rcount_in = '0;
         end
         CMD_READ: rd_en = in_range;
         default:  rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         toggle_ff <= 1'b1;
         pulse_ff  <= '0;
         seek_ff   <= '0;
         widx_ff   <= '0;
         rcount_ff <= '0;
      end else if (cmd.step) begin
         phase_ff  <= phase_in;
         toggle_ff <= toggle_in;
         pulse_ff  <= pulse_in;
         seek_ff   <= seek_in;
         widx_ff   <= widx_in;
         rcount_ff <= rcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         pend_ff   <= pend_in;
         status_ff <= phase_in;
         count_ff  <= (phase_in == PH_DONE) ? rcount_in : '0;
         rd_sel_ff <= rd_en;
      end
   end

   rpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (cfg.divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign ram_we    = (cmd.step && zero_we) || cmd.store_div || cmd.store_zero2;
   assign ram_waddr = cmd.step ? widx_ff[AW-1:0] : pend_ff;
   assign ram_wdata = cmd.store_div ? quotient : '0;

   rpt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.step && rd_en),
      .raddr (AW'(req_index)),
      .rdata (ram_rdata)
   );

   assign dp_status.action   = action;
   assign dp_status.div_done = div_done;

   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;
   assign rsp_data   = rd_sel_ff ? ram_rdata : '0;

endmodule

### rtl/rf_pulse_train_capture.sv
`timescale 1ns / 1ps

// Pulse-train capture for an on-off keyed receiver data line. Each request
// is a sample tick, a start command or a buffer read, and each gives one
// response with the capture status, the entry count after a successful
// capture and the read value. A tick that closes a pulse (or accepts the
// preamble) holds off the next request while the bit-serial divider scales
// the pulse length, one quotient bit per cycle, before the buffer write. A
// tick that ends a successful capture by timeout clears the buffer slot
// after the last entry and, where the buffer holds it, the slot after that,
// and holds off the next request until that second slot is cleared. Read
// data comes from the buffer's registered port and is presented with the
// response the cycle after the request. A new request is taken only once
// the previous response leaves, at the earliest in the same cycle.
module rf_pulse_train_capture #(
   parameter int BUFFER_DEPTH = rpt_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // rf_level, read_index
   input  logic [rpt_pkg::CMD_W-1:0]         req_tuser,  // command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // status, pulse_count, read_data
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rpt_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [rpt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rpt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   import rpt_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          csr_write;
   logic [2:0]    csr_index;
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;
   logic [VALUE_W-1:0]  rsp_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PREAMBLE_MIN: cfg_in.preamble_min = csr_pwdata[TICK_W-1:0];
            REG_PULSE_MIN:    cfg_in.pulse_min    = csr_pwdata[TICK_W-1:0];
            REG_END_TIMEOUT:  cfg_in.end_timeout  = csr_pwdata[TICK_W-1:0];
            REG_SEEK_TIMEOUT: cfg_in.seek_timeout = csr_pwdata[SEEK_W-1:0];
            REG_DIVISOR:      cfg_in.divisor      = csr_pwdata[DIVISOR_W-1:0];
            REG_MIN_COUNT:    cfg_in.min_count    = csr_pwdata[MINCNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PREAMBLE_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.preamble_min);
         REG_PULSE_MIN:    csr_prdata = CSR_DATA_W'(cfg_ff.pulse_min);
         REG_END_TIMEOUT:  csr_prdata = CSR_DATA_W'(cfg_ff.end_timeout);
         REG_SEEK_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.seek_timeout);
         REG_DIVISOR:      csr_prdata = CSR_DATA_W'(cfg_ff.divisor);
         REG_MIN_COUNT:    csr_prdata = CSR_DATA_W'(cfg_ff.min_count);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_min <= RST_PREAMBLE_MIN;
         cfg_ff.pulse_min    <= RST_PULSE_MIN;
         cfg_ff.end_timeout  <= RST_END_TIMEOUT;
         cfg_ff.seek_timeout <= RST_SEEK_TIMEOUT;
         cfg_ff.divisor      <= RST_DIVISOR;
         cfg_ff.min_count    <= RST_MIN_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   rpt_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .req_command (req_tuser),
      .req_level   (req_tdata[0]),
      .req_index   (req_tdata[INDEX_W:1]),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .rsp_data    (rsp_data)
   );

   assign rsp_tdata = {4'd0, rsp_data, rsp_count, rsp_status};

endmodule
